FILE: design/mdt_pkg.sv
package mdt_pkg;

	typedef enum logic [2:0] {
		OP_EQUAL    = 3'd0,
		OP_MISMATCH = 3'd1,
		OP_DELETE   = 3'd2,
		OP_END      = 3'd3,
		OP_IGNORE   = 3'd4
	} op_t;

	// residual width: enough for the eight-digit cap
	localparam int DIG_W = 27;
	localparam int POS_W = 3;
	localparam int NUM_POS = 8;
	localparam logic [63:0] DIGIT_CAP = 64'd99999999;

	localparam logic [7:0] CHAR_CARET = 8'h5E;
	localparam logic [7:0] CHAR_N     = 8'h4E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;
	localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_C     = 8'h43;
	localparam logic [7:0] CHAR_G     = 8'h47;
	localparam logic [7:0] CHAR_T     = 8'h54;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	// pending work for one item, handed from the decoder to the sequencer
	typedef struct packed {
		logic             dig_pend;
		logic [DIG_W-1:0] res;
		logic [POS_W-1:0] pos;
		logic             dig_last;
		logic             caret_pend;
		logic             tail_pend;
		logic [7:0]       tail_char;
		logic             tail_valid;
		logic             tail_last;
	} job_t;

	// m times ten to the power p, for elaboration-time tables
	function automatic logic [DIG_W-1:0] dec_weight(input int p, input int m);
		logic [63:0] w;
		w = 64'(m);
		for (int i = 0; i < p; i++) begin
			w = w * 64'd10;
		end
		return w[DIG_W-1:0];
	endfunction

	function automatic logic [7:0] upper_base(input logic [7:0] b, input logic in_window);
		logic [7:0] u;
		u = b;
		if (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) begin
			u = b - CASE_DIFF;
		end
		if (!in_window) begin
			return CHAR_N;
		end
		if (u == CHAR_A || u == CHAR_C || u == CHAR_G || u == CHAR_T) begin
			return u;
		end
		return CHAR_N;
	endfunction

endpackage

FILE: design/mdt_in_if.sv
interface mdt_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [23:0] run_length;
	logic [7:0]  ref_letter;
	logic        ref_in_window;
	logic        op_start;

	modport source (
		output valid, operation, run_length, ref_letter, ref_in_window, op_start,
		input  ready
	);

	modport sink (
		input  valid, operation, run_length, ref_letter, ref_in_window, op_start,
		output ready
	);
endinterface

FILE: design/mdt_out_if.sv
interface mdt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] md_char;
	logic       char_valid;
	logic       last;

	modport source (
		output valid, md_char, char_valid, last,
		input  ready
	);

	modport sink (
		input  valid, md_char, char_valid, last,
		output ready
	);
endinterface

FILE: design/mdt_sequencer.sv
module mdt_sequencer
	import mdt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  job_t       load_job,
	output logic       take,
	mdt_out_if.source  md
);

	job_t job_q;

	// weight table: entry [p][m] is m * 10^p
	logic [DIG_W-1:0] mult_tbl [NUM_POS][11];

	for (genvar p = 0; p < NUM_POS; p++) begin : g_pos
		for (genvar m = 0; m < 11; m++) begin : g_mul
			assign mult_tbl[p][m] = dec_weight(p, m);
		end
	end

	logic             busy;
	logic             emit;
	logic             final_piece;
	logic [3:0]       digit;
	logic [DIG_W-1:0] res_next;
	logic [7:0]       piece_char;
	logic             piece_valid;
	logic             piece_last;

	assign busy = job_q.dig_pend | job_q.caret_pend | job_q.tail_pend;
	assign emit = busy && (!md.valid || md.ready);

	always_comb begin
		digit = '0;
		for (int m = 1; m < 10; m++) begin
			if (job_q.res >= mult_tbl[job_q.pos][m]) begin
				digit = 4'(m);
			end
		end
		res_next = job_q.res - mult_tbl[job_q.pos][digit];
	end

	always_comb begin
		final_piece = 1'b0;
		piece_char  = job_q.tail_char;
		piece_valid = job_q.tail_valid;
		piece_last  = job_q.tail_last;
		if (job_q.dig_pend) begin
			piece_char  = CHAR_ZERO + 8'(digit);
			piece_valid = 1'b1;
			piece_last  = job_q.dig_last && (job_q.pos == '0);
			final_piece = (job_q.pos == '0) && !job_q.caret_pend && !job_q.tail_pend;
		end else if (job_q.caret_pend) begin
			piece_char  = CHAR_CARET;
			piece_valid = 1'b1;
			piece_last  = 1'b0;
			final_piece = !job_q.tail_pend;
		end else begin
			final_piece = 1'b1;
		end
	end

	// a new job may enter as the current one sends its final piece
	assign take = !busy || (emit && final_piece);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q.dig_pend   <= 1'b0;
			job_q.caret_pend <= 1'b0;
			job_q.tail_pend  <= 1'b0;
		end else if (load) begin
			job_q <= load_job;
		end else if (emit) begin
			if (job_q.dig_pend) begin
				job_q.res <= res_next;
				if (job_q.pos == '0) begin
					job_q.dig_pend <= 1'b0;
				end else begin
					job_q.pos <= job_q.pos - POS_W'(1);
				end
			end else if (job_q.caret_pend) begin
				job_q.caret_pend <= 1'b0;
			end else begin
				job_q.tail_pend <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md.valid <= 1'b0;
		end else if (emit) begin
			md.valid <= 1'b1;
		end else if (md.ready) begin
			md.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			md.md_char    <= piece_char;
			md.char_valid <= piece_valid;
			md.last       <= piece_last;
		end
	end

`ifndef SYNTHESIS
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_q.dig_pend |-> job_q.res < mult_tbl[job_q.pos][10])
		else $error("digit residual exceeds its position");

	a_term_form: assert property (@(posedge clk) disable iff (!arst_n)
		(md.valid && !md.char_valid) |-> (md.last && md.md_char == 8'h00))
		else $error("empty terminator malformed");

	a_job_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && final_piece && !load) |=> !busy)
		else $error("job still pending after final piece");
`endif

endmodule

FILE: design/md_tag_encoder.sv
// MD tag encoder: takes one alignment edit element per transfer on edits and
// produces the SAM MD string on md, one character per transfer. Equal runs,
// ignored ops and continuation bases are taken one per cycle while md does not
// stall. An item that flushes the match count holds off the next item until its
// digits, a caret for a deletion and its base are sent, as the digit sequencer
// turns the count into decimal one digit per cycle unless md stalls, most
// significant first; the next item enters as the last character leaves. The
// count saturates at the lesser of 2^COUNT_BITS - 1 and 99999999.
module md_tag_encoder
	import mdt_pkg::*;
#(
	parameter int COUNT_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	mdt_in_if.sink    edits,
	mdt_out_if.source md
);

	localparam logic [63:0] CNT_FULL = (64'd1 << COUNT_BITS) - 64'd1;
	localparam logic [63:0] CNT_MAX  = (CNT_FULL < DIGIT_CAP) ? CNT_FULL : DIGIT_CAP;

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_d;
	logic [32:0]           sum;
	logic [31:0]           count_wide;
	logic [DIG_W-1:0]      count_ext;
	logic [POS_W-1:0]      npos;
	logic                  take;
	logic                  accept;
	logic                  load;
	job_t                  load_job;
	op_t                   op;

	assign op         = op_t'(edits.operation);
	assign accept     = edits.valid && edits.ready;
	assign edits.ready = take;

	assign count_wide = 32'(count_q);
	assign count_ext  = count_wide[DIG_W-1:0];
	assign sum        = 33'(count_q) + 33'(edits.run_length);

	// leading digit position of the pending count
	always_comb begin
		npos = '0;
		for (int k = 1; k < NUM_POS; k++) begin
			if (count_ext >= dec_weight(k, 1)) begin
				npos = POS_W'(k);
			end
		end
	end

	always_comb begin
		count_d             = count_q;
		load                = 1'b0;
		load_job.dig_pend   = 1'b0;
		load_job.res        = count_ext;
		load_job.pos        = npos;
		load_job.dig_last   = 1'b0;
		load_job.caret_pend = 1'b0;
		load_job.tail_pend  = 1'b0;
		load_job.tail_char  = upper_base(edits.ref_letter, edits.ref_in_window);
		load_job.tail_valid = 1'b1;
		load_job.tail_last  = 1'b0;
		unique case (op) inside
			OP_EQUAL: begin
				if (sum > CNT_MAX[32:0]) begin
					count_d = COUNT_BITS'(CNT_MAX);
				end else begin
					count_d = COUNT_BITS'(sum);
				end
			end
			OP_MISMATCH, OP_DELETE: begin
				load                = 1'b1;
				load_job.dig_pend   = edits.op_start;
				load_job.caret_pend = edits.op_start && (op == OP_DELETE);
				load_job.tail_pend  = 1'b1;
				if (edits.op_start) begin
					count_d = '0;
				end
			end
			OP_END: begin
				load    = 1'b1;
				count_d = '0;
				if (count_q != '0) begin
					load_job.dig_pend = 1'b1;
					load_job.dig_last = 1'b1;
				end else begin
					load_job.tail_pend  = 1'b1;
					load_job.tail_char  = 8'h00;
					load_job.tail_valid = 1'b0;
					load_job.tail_last  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	mdt_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && load),
		.load_job (load_job),
		.take     (take),
		.md       (md)
	);

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		64'(count_q) <= CNT_MAX)
		else $error("match count above its cap");

	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && edits.op_start && (op == OP_MISMATCH || op == OP_DELETE))
		|=> count_q == '0)
		else $error("count not cleared after flush");

	a_run_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_EQUAL) |=> count_q >= $past(count_q))
		else $error("equal run decreased the count");
`endif

endmodule
